### rtl/bma_pkg.sv
// Shared constants, types and operation codes for the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

    localparam int MAX_BITS  = 1024;
    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = MAX_BITS / WORD_W;
    localparam int POS_W     = $clog2(MAX_BITS);
    localparam int SIZE_W    = POS_W + 1;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam int CNT_W     = BIT_W + 1;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    // Read and write request from the sequencer to the bitmap store.
    typedef struct packed {
        logic  rd_en;
        t_addr rd_addr;
        logic  wr_en;
        t_addr wr_addr;
        t_word wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

### rtl/bma_if.sv
// Request and response channel interfaces of the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

interface bma_req_if;
    logic                      valid;
    logic                      ready;
    logic [bma_pkg::OP_W-1:0]  opcode;
    logic [bma_pkg::POS_W-1:0] position;
    logic                      write_value;

    modport source (output valid, output opcode, output position, output write_value,
                    input ready);
    modport sink (input valid, input opcode, input position, input write_value,
                  output ready);
endinterface

interface bma_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      in_range;
    logic                      bit_read;
    logic                      free_found;
    logic [bma_pkg::POS_W-1:0] free_position;

    modport source (output valid, output in_range, output bit_read, output free_found,
                    output free_position, input ready);
    modport sink (input valid, input in_range, input bit_read, input free_found,
                  input free_position, output ready);
endinterface

`default_nettype wire

### rtl/bma_mem.sv
// Word-organized bitmap store with per-row valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module bma_mem (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire bma_pkg::t_mem_req i_req,
    output bma_pkg::t_word         o_rd_data
);

    bma_pkg::t_word                    r_mem [bma_pkg::NUM_WORDS];
    logic [bma_pkg::NUM_WORDS-1:0]     r_row_vld;
    bma_pkg::t_word                    r_rd_data;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // A row never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### rtl/bma_ffz.sv
// Find-first-zero unit over one bitmap word, limited to its lowest bits.
`timescale 1ns / 1ps
`default_nettype none

module bma_ffz (
    input  wire bma_pkg::t_word           i_word,
    input  wire [bma_pkg::CNT_W-1:0]      i_limit,
    output logic                          o_found,
    output logic [bma_pkg::BIT_W-1:0]     o_index
);

    bma_pkg::t_word free_bits;

    always_comb begin
        for (int b = 0; b < bma_pkg::WORD_W; b++) begin
            free_bits[b] = !i_word[b] && (bma_pkg::CNT_W'(b) < i_limit);
        end
    end

    always_comb begin
        o_index = '0;
        for (int b = bma_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_index = bma_pkg::BIT_W'(b);
            end
        end
    end

    assign o_found = |free_bits;

endmodule

`default_nettype wire

### rtl/bitmap_allocator.sv
// Top level of the bitmap allocator: sequencer, size register and result register.
//
//  Channel   Direction  Word contents
//  i_req     in         opcode, position, write_value
//  o_rsp     out        in_range, bit_read, free_found, free_position
//  i_cfg_*   in         bits_in_use (11 bits, write only)
//
// Out-of-range requests and a find on an empty bitmap are answered from the idle state;
// test reads the word; write and clear read then write back the word. Find reads one
// 32-bit word per cycle from the store until the first clear bit below the size or the
// last word in use. Reset is synchronous; the store needs no clearing pass since the
// row valid bits make unwritten rows read as zero. A new word is taken only in the idle
// state while the result register is empty or being drained.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    bma_req_if.sink                      i_req,
    bma_rsp_if.source                    o_rsp,
    input  wire                          i_cfg_we,
    input  wire [bma_pkg::SIZE_W-1:0]    i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]                   r_state, n_state;
    logic [bma_pkg::OP_W-1:0]     r_op, n_op;
    logic [bma_pkg::BIT_W-1:0]    r_bit, n_bit;
    bma_pkg::t_addr               r_word, n_word;
    logic                         r_wv, n_wv;
    bma_pkg::t_addr               r_chk, n_chk;
    logic [bma_pkg::SIZE_W-1:0]   r_size;

    logic                         r_out_vld, n_out_vld;
    logic                         r_out_in_range, n_out_in_range;
    logic                         r_out_bit, n_out_bit;
    logic                         r_out_found, n_out_found;
    logic [bma_pkg::POS_W-1:0]    r_out_pos, n_out_pos;

    bma_pkg::t_mem_req            mem_req;
    bma_pkg::t_word               mem_rdata;
    bma_pkg::t_word               mod_word;
    logic [bma_pkg::SIZE_W-1:0]   size_m1;
    bma_pkg::t_addr               last_word;
    logic [bma_pkg::CNT_W-1:0]    tail_cnt;
    logic [bma_pkg::CNT_W-1:0]    ffz_limit;
    logic                         ffz_found;
    logic [bma_pkg::BIT_W-1:0]    ffz_index;
    logic                         accept;
    logic                         in_rng;

    bma_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rdata)
    );

    bma_ffz u_ffz (
        .i_word  (mem_rdata),
        .i_limit (ffz_limit),
        .o_found (ffz_found),
        .o_index (ffz_index)
    );

    assign size_m1   = r_size - bma_pkg::SIZE_W'(1);
    assign last_word = size_m1[bma_pkg::POS_W-1:bma_pkg::BIT_W];
    assign tail_cnt  = (r_size[bma_pkg::BIT_W-1:0] == '0)
                       ? bma_pkg::CNT_W'(bma_pkg::WORD_W)
                       : {1'b0, r_size[bma_pkg::BIT_W-1:0]};
    assign ffz_limit = (r_chk == last_word) ? tail_cnt : bma_pkg::CNT_W'(bma_pkg::WORD_W);

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_vld || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign in_rng      = {1'b0, i_req.position} < r_size;

    always_comb begin
        mod_word        = mem_rdata;
        mod_word[r_bit] = (r_op == bma_pkg::OP_WRITE) ? r_wv : 1'b0;
    end

    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_bit          = r_bit;
        n_word         = r_word;
        n_wv           = r_wv;
        n_chk          = r_chk;
        n_out_vld      = r_out_vld && !o_rsp.ready;
        n_out_in_range = r_out_in_range;
        n_out_bit      = r_out_bit;
        n_out_found    = r_out_found;
        n_out_pos      = r_out_pos;
        mem_req        = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_req.opcode;
                    n_bit  = i_req.position[bma_pkg::BIT_W-1:0];
                    n_word = i_req.position[bma_pkg::POS_W-1:bma_pkg::BIT_W];
                    n_wv   = i_req.write_value;
                    // Default result: all fields zero, used by the out-of-range and empty-find cases.
                    n_out_in_range = 1'b0;
                    n_out_bit      = 1'b0;
                    n_out_found    = 1'b0;
                    n_out_pos      = '0;
                    if (i_req.opcode == bma_pkg::OP_FIND) begin
                        if (r_size == '0) begin
                            n_out_vld = 1'b1;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            n_chk           = '0;
                            n_state         = S_SCAN;
                        end
                    end else if (in_rng) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = i_req.position[bma_pkg::POS_W-1:bma_pkg::BIT_W];
                        n_state         = S_ACC;
                    end else begin
                        n_out_vld = 1'b1;
                    end
                end
            end
            S_ACC: begin
                n_out_vld      = 1'b1;
                n_out_in_range = 1'b1;
                if (r_op == bma_pkg::OP_TEST) begin
                    n_out_bit = mem_rdata[r_bit];
                end else begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = r_word;
                    mem_req.wr_data = mod_word;
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // Next word is fetched while the current one is checked.
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_chk + bma_pkg::ADDR_W'(1);
                n_chk           = r_chk + bma_pkg::ADDR_W'(1);
                if (ffz_found) begin
                    n_out_vld   = 1'b1;
                    n_out_found = 1'b1;
                    n_out_pos   = {r_chk, ffz_index};
                    n_state     = S_IDLE;
                end else if (r_chk == last_word) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_size    <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_size <= (i_cfg_wdata > bma_pkg::SIZE_W'(bma_pkg::MAX_BITS))
                          ? bma_pkg::SIZE_W'(bma_pkg::MAX_BITS) : i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_bit          <= n_bit;
        r_word         <= n_word;
        r_wv           <= n_wv;
        r_chk          <= n_chk;
        r_out_in_range <= n_out_in_range;
        r_out_bit      <= n_out_bit;
        r_out_found    <= n_out_found;
        r_out_pos      <= n_out_pos;
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.in_range      = r_out_in_range;
    assign o_rsp.bit_read      = r_out_bit;
    assign o_rsp.free_found    = r_out_found;
    assign o_rsp.free_position = r_out_pos;

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_size != '0)
        else $error("scan running with an empty bitmap");

    a_found_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_found |-> {1'b0, r_out_pos} < r_size)
        else $error("free position beyond bits in use");

    a_find_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_in_range && r_out_found))
        else $error("result mixes find and bit access fields");

    a_bit_needs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_bit |-> r_out_in_range)
        else $error("bit read reported out of range");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.opcode != bma_pkg::OP_FIND) && in_rng |=> !i_req.ready)
        else $error("new word taken while a bit access is in flight");

endmodule

`default_nettype wire
